FILE: rtl/core/crsc_pkg.sv
// ----------------------------------------------------------------------------
// Column-to-row span converter package
// Shared sizes, the infinite-top marker and the command passed from the
// front end to the back end through the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

package crsc_pkg;

    localparam int ROWS        = 64;
    localparam int COLS        = 1024;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int POS_W       = ROW_W + 1;
    localparam int COL_W       = $clog2(COLS) + 1;
    localparam int SPAN_COL_W  = $clog2(COLS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // An empty column has its top beyond every row.
    localparam logic [POS_W-1:0] POS_INF = {POS_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0] t1;
        logic [ROW_W-1:0] b1;
        logic [POS_W-1:0] t2;
        logic [ROW_W-1:0] b2;
        logic [COL_W-1:0] column;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/crsc_if.sv
// ----------------------------------------------------------------------------
// Column-to-row span converter channels
// Valid/ready channels for column extents coming in and row spans going out.
// ----------------------------------------------------------------------------
`default_nettype none

interface crsc_extent_if import crsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic             column_empty;
    logic             plane_start;

    modport source (
        output valid, column, top_row, bottom_row, column_empty, plane_start,
        input  ready
    );
    modport sink (
        input  valid, column, top_row, bottom_row, column_empty, plane_start,
        output ready
    );
endinterface

interface crsc_span_if import crsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ROW_W-1:0]      span_row;
    logic [SPAN_COL_W-1:0] span_first_column;
    logic [SPAN_COL_W-1:0] span_last_column;
    logic                  last_span;

    modport source (
        output valid, span_row, span_first_column, span_last_column, last_span,
        input  ready
    );
    modport sink (
        input  valid, span_row, span_first_column, span_last_column, last_span,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/column_to_row_span_converter.sv
// ----------------------------------------------------------------------------
// Column-to-row span converter
// Turns a stream of per-column vertical extents into horizontal row spans.
// ----------------------------------------------------------------------------
// Each column extent closes the rows that the previous column covered and
// this one does not, one span per row, first going down from the old top and
// then up from the old bottom, with last_span set on the final span of the
// column; it then records its column as the start of the rows it opens. The
// back end handles one row per cycle, and the rows that a column closes plus
// the rows that it opens number at most 64; the start-column memory has a
// single write or read each cycle. A two-entry command queue lets new columns
// be accepted while earlier ones are still being worked, and a waiting span
// only stalls the closing of rows. Send an empty column at the end of a
// surface to close every open span.
// ----------------------------------------------------------------------------
`default_nettype none

module column_to_row_span_converter import crsc_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    crsc_extent_if.sink   extent,
    crsc_span_if.source   span
);

    cmd_t push_cmd;
    logic push_valid;
    logic push_ready;
    cmd_t pop_cmd;
    logic pop_valid;
    logic pop_ready;

    crsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .extent     (extent),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    crsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    crsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_cmd   (pop_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .span      (span)
    );

    // Every accepted transaction becomes a command in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        extent.valid && extent.ready |-> push_valid && push_ready)
    else $error("accepted extent was not pushed to the command queue");

    // The back end never takes two commands in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> !pop_ready)
    else $error("back end took two commands in consecutive cycles");

    // A finite previous top always names a real row.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_cmd.t1 == POS_INF) || (push_cmd.t1 < POS_W'(ROWS)))
    else $error("command carries an out-of-range previous top");

endmodule

`default_nettype wire

FILE: rtl/core/crsc_front.sv
// ----------------------------------------------------------------------------
// Column-to-row span converter front end
// Accepts column extents, resolves empty columns and surface starts against
// the previous column and pushes one command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module crsc_front import crsc_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    crsc_extent_if.sink extent,
    output cmd_t        push_cmd,
    output logic        push_valid,
    input  wire logic   push_ready
);

    logic [ROW_W-1:0] prev_top_reg;
    logic [ROW_W-1:0] prev_top_next;
    logic [ROW_W-1:0] prev_bottom_reg;
    logic [ROW_W-1:0] prev_bottom_next;
    logic             prev_empty_reg;
    logic             prev_empty_next;
    logic             accept;

    assign extent.ready = push_ready;
    assign push_valid   = extent.valid;
    assign accept       = extent.valid && push_ready;

    always_comb
    begin
        push_cmd.t1     = (extent.plane_start || prev_empty_reg) ? POS_INF
                                                                 : {1'b0, prev_top_reg};
        push_cmd.b1     = prev_bottom_reg;
        push_cmd.t2     = extent.column_empty ? POS_INF : {1'b0, extent.top_row};
        push_cmd.b2     = extent.bottom_row;
        push_cmd.column = extent.column;
    end

    always_comb
    begin
        prev_top_next    = prev_top_reg;
        prev_bottom_next = prev_bottom_reg;
        prev_empty_next  = prev_empty_reg;
        if (accept)
        begin
            prev_top_next    = extent.top_row;
            prev_bottom_next = extent.bottom_row;
            prev_empty_next  = extent.column_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_top_reg    <= '0;
            prev_bottom_reg <= '0;
            prev_empty_reg  <= 1'b1;
        end
        else
        begin
            prev_top_reg    <= prev_top_next;
            prev_bottom_reg <= prev_bottom_next;
            prev_empty_reg  <= prev_empty_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/crsc_queue.sv
// ----------------------------------------------------------------------------
// Column-to-row span converter command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module crsc_queue import crsc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t push_cmd,
    input  wire logic push_valid,
    output logic      push_ready,
    output cmd_t      pop_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/crsc_back.sv
// ----------------------------------------------------------------------------
// Column-to-row span converter back end
// Steps through the rows of one command, closing spans through the output
// register and recording span starts in the start-column memory.
// ----------------------------------------------------------------------------
`default_nettype none

module crsc_back import crsc_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cmd_t   pop_cmd,
    input  wire logic   pop_valid,
    output logic        pop_ready,
    crsc_span_if.source span
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_CLOSE_TOP = 5'b00010,
        S_CLOSE_BOT = 5'b00100,
        S_OPEN_TOP  = 5'b01000,
        S_OPEN_BOT  = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [POS_W-1:0]      t1_reg;
    logic [POS_W-1:0]      t1_next;
    logic [ROW_W-1:0]      b1_reg;
    logic [ROW_W-1:0]      b1_next;
    logic [POS_W-1:0]      t2_reg;
    logic [POS_W-1:0]      t2_next;
    logic [ROW_W-1:0]      b2_reg;
    logic [ROW_W-1:0]      b2_next;
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [COL_W-1:0]      col_dec;

    logic [COL_W-1:0]      start_mem [ROWS];
    logic                  mem_we;
    logic [ROW_W-1:0]      wr_addr;
    logic [ROW_W-1:0]      rd_addr;

    logic                  span_valid_reg;
    logic                  span_valid_next;
    logic [ROW_W-1:0]      span_row_reg;
    logic [SPAN_COL_W-1:0] span_first_reg;
    logic [SPAN_COL_W-1:0] span_last_reg;
    logic                  last_span_reg;
    logic                  emit;
    logic                  emit_last;
    logic                  out_free;

    logic [POS_W-1:0]      b1_ext;
    logic [POS_W-1:0]      b2_ext;
    logic [POS_W-1:0]      t1_inc;
    logic [ROW_W-1:0]      b1_dec;
    logic                  close_top;
    logic                  close_bot;
    logic                  open_top;
    logic                  open_bot;
    logic                  more_after_top;
    logic                  more_after_bot;

    assign b1_ext   = {1'b0, b1_reg};
    assign b2_ext   = {1'b0, b2_reg};
    assign t1_inc   = t1_reg + 1'b1;
    assign b1_dec   = b1_reg - 1'b1;
    assign col_dec  = col_reg - 1'b1;
    assign out_free = !span_valid_reg || span.ready;

    assign close_top = (t1_reg < t2_reg) && (t1_reg <= b1_ext);
    assign close_bot = (b1_reg > b2_reg) && (b1_ext >= t1_reg);
    assign open_top  = (t2_reg < t1_reg) && (t2_reg <= b2_ext);
    assign open_bot  = (b2_reg > b1_reg) && (b2_ext >= t2_reg);

    assign more_after_top = ((t1_inc < t2_reg) && (t1_inc <= b1_ext))
                         || ((b1_reg > b2_reg) && (b1_ext >= t1_inc));
    assign more_after_bot = (b1_dec > b2_reg) && ({1'b0, b1_dec} >= t1_reg);

    always_comb
    begin
        state_next = state_reg;
        t1_next    = t1_reg;
        b1_next    = b1_reg;
        t2_next    = t2_reg;
        b2_next    = b2_reg;
        col_next   = col_reg;
        pop_ready  = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        mem_we     = 1'b0;
        wr_addr    = '0;
        rd_addr    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    t1_next    = pop_cmd.t1;
                    b1_next    = pop_cmd.b1;
                    t2_next    = pop_cmd.t2;
                    b2_next    = pop_cmd.b2;
                    col_next   = pop_cmd.column;
                    state_next = S_CLOSE_TOP;
                end
            end
            S_CLOSE_TOP:
            begin
                if (!close_top)
                begin
                    state_next = S_CLOSE_BOT;
                end
                else if (out_free)
                begin
                    emit      = 1'b1;
                    emit_last = !more_after_top;
                    rd_addr   = t1_reg[ROW_W-1:0];
                    t1_next   = t1_inc;
                end
            end
            S_CLOSE_BOT:
            begin
                if (!close_bot)
                begin
                    state_next = S_OPEN_TOP;
                end
                else if (out_free)
                begin
                    emit      = 1'b1;
                    emit_last = !more_after_bot;
                    rd_addr   = b1_reg;
                    b1_next   = b1_dec;
                end
            end
            S_OPEN_TOP:
            begin
                if (open_top)
                begin
                    mem_we  = 1'b1;
                    wr_addr = t2_reg[ROW_W-1:0];
                    t2_next = t2_reg + 1'b1;
                end
                else
                begin
                    state_next = S_OPEN_BOT;
                end
            end
            S_OPEN_BOT:
            begin
                if (open_bot)
                begin
                    mem_we  = 1'b1;
                    wr_addr = b2_reg;
                    b2_next = b2_reg - 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        span_valid_next = span_valid_reg;
        if (emit)
        begin
            span_valid_next = 1'b1;
        end
        else if (span.ready)
        begin
            span_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            start_mem[wr_addr] <= col_reg;
        end
        if (emit)
        begin
            span_first_reg <= start_mem[rd_addr][SPAN_COL_W-1:0];
            span_row_reg   <= rd_addr;
            span_last_reg  <= col_dec[SPAN_COL_W-1:0];
            last_span_reg  <= emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= t1_next;
        b1_reg  <= b1_next;
        t2_reg  <= t2_next;
        b2_reg  <= b2_next;
        col_reg <= col_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            span_valid_reg <= span_valid_next;
        end
    end

    assign span.valid             = span_valid_reg;
    assign span.span_row          = span_row_reg;
    assign span.span_first_column = span_first_reg;
    assign span.span_last_column  = span_last_reg;
    assign span.last_span         = last_span_reg;

endmodule

`default_nettype wire
